>>> sv/rle_pkg.sv
// Shared constants, opcode codes, field helpers and inter-module structs of the
// small integer execute core. Depends on nothing; every other file imports it.
package rle_pkg;

    localparam int DATA_WORDS     = 1024;
    localparam int PROGRAM_WORDS  = 1024;
    localparam int REGISTER_COUNT = 32;

    localparam int WORD_W     = 32;
    localparam int DATA_AW    = $clog2(DATA_WORDS);
    localparam int PC_W       = $clog2(PROGRAM_WORDS);
    localparam int REG_AW     = $clog2(REGISTER_COUNT);
    localparam int NEXT_PC_W  = 10;
    localparam int PRELOAD_AW = 10;

    localparam logic KIND_PRELOAD = 1'b0;
    localparam logic KIND_EXEC    = 1'b1;

    typedef enum logic [5:0] {
        OP_ADD  = 6'd0,
        OP_ADDI = 6'd1,
        OP_SUB  = 6'd2,
        OP_SUBI = 6'd3,
        OP_MUL  = 6'd4,
        OP_MULI = 6'd5,
        OP_OR   = 6'd6,
        OP_ORI  = 6'd7,
        OP_AND  = 6'd8,
        OP_ANDI = 6'd9,
        OP_XOR  = 6'd10,
        OP_XORI = 6'd11,
        OP_LDW  = 6'd12,
        OP_STW  = 6'd13,
        OP_BZ   = 6'd14,
        OP_BEQ  = 6'd15,
        OP_JR   = 6'd16,
        OP_HALT = 6'd17
    } instr_op_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic              halted;
        logic              taken;
        logic              written;
        logic [REG_AW-1:0] dest;
        logic [WORD_W-1:0] value;
        logic              store_done;
        logic              is_load;
    } exec_result_t;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [DATA_AW-1:0] addr;
        logic [WORD_W-1:0]  wr_data;
    } dmem_req_t;

    function automatic logic [REG_AW-1:0] get_rs(input logic [WORD_W-1:0] word);
        return word[25:21];
    endfunction

    function automatic logic [REG_AW-1:0] get_rt(input logic [WORD_W-1:0] word);
        return word[20:16];
    endfunction

    function automatic logic [REG_AW-1:0] get_rd(input logic [WORD_W-1:0] word);
        return word[15:11];
    endfunction

endpackage

>>> sv/risc_lite_execute_core.sv
// An accepted transfer passes the execute stage, then the output stage, where its result shows.
// Throughput: one transfer per cycle while in_stall is low; the 32x32 multiply is combinational.
// Reset: pc and registers read as zero at once; a sweep then zeroes all 1024 data memory words,
// and in_stall stays high until the sweep has finished.
// Top level of the integer execute core. Depends on rle_pkg, rle_regfile, rle_dmem, rle_exec.
module risc_lite_execute_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [31:0]        instruction_word,
    input  logic [9:0]         preload_address,
    input  logic signed [31:0] preload_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [9:0]         next_pc,
    output logic               halted,
    output logic               branch_taken,
    output logic               dest_written,
    output logic [4:0]         dest_index,
    output logic signed [31:0] result_value,
    output logic               store_done
);
    import rle_pkg::*;

    // The pipeline has two stages. The execute stage holds the accepted transfer
    // together with the register operands read at the accepting edge. The output
    // stage holds the finished result until the consumer takes it; a load's data
    // comes straight from the data memory's read register, which only changes
    // when a new transfer enters the output stage.

    // Handshake and stage control.
    logic               accept;
    logic               out_load;
    logic               ex_adv;
    logic               ex_free;
    logic               dmem_busy;

    logic               ex_valid_reg;
    logic               ex_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_wpend_reg;

    // Execute stage payload.
    logic               ex_kind_reg;
    logic [WORD_W-1:0]  ex_instr_reg;
    logic [PRELOAD_AW-1:0] ex_pre_addr_reg;
    logic [WORD_W-1:0]  ex_pre_val_reg;

    // Operand patch registers: a register written by an older instruction at or
    // after the read edge replaces the stale value read from the file.
    logic               ex_ovr_a_reg;
    logic               ex_ovr_b_reg;
    logic [WORD_W-1:0]  ex_ovr_a_val_reg;
    logic [WORD_W-1:0]  ex_ovr_b_val_reg;

    logic [PC_W-1:0]    pc_reg;
    exec_result_t       out_res_reg;

    logic [REG_AW-1:0]  ex_rs;
    logic [REG_AW-1:0]  ex_rt;
    logic [WORD_W-1:0]  rf_data_a;
    logic [WORD_W-1:0]  rf_data_b;
    logic               rf_we;
    logic [REG_AW-1:0]  rf_waddr;
    logic [WORD_W-1:0]  rf_wdata;
    logic [WORD_W-1:0]  op_a;
    logic [WORD_W-1:0]  op_b;
    logic [WORD_W-1:0]  dmem_rdata;
    logic [WORD_W-1:0]  final_value;

    exec_result_t       ex_res;
    dmem_req_t          ex_mem_req;

    // The output stage can take a new result when it is empty or is being read
    // this cycle; the execute stage frees up whenever its content moves on.
    assign out_load = !out_valid_reg || !out_stall;
    assign ex_adv   = ex_valid_reg && out_load;
    assign ex_free  = !ex_valid_reg || ex_adv;
    assign in_stall = dmem_busy || !ex_free;
    assign accept   = in_valid && !in_stall;

    assign ex_valid_next  = accept ? 1'b1 : (ex_adv ? 1'b0 : ex_valid_reg);
    assign out_valid_next = ex_adv ? 1'b1 : (out_load ? 1'b0 : out_valid_reg);

    assign ex_rs = get_rs(ex_instr_reg);
    assign ex_rt = get_rt(ex_instr_reg);

    // Each result writes the register file once, at the edge that ends its first
    // cycle in the output stage, so a load's data is available by then.
    assign final_value = out_res_reg.is_load ? dmem_rdata : out_res_reg.value;
    assign rf_we       = out_valid_reg && out_wpend_reg && out_res_reg.written;
    assign rf_waddr    = out_res_reg.dest;
    assign rf_wdata    = final_value;

    // The only write still outstanding while an instruction executes is that of
    // the result just ahead of it, so it is forwarded directly.
    always_comb
    begin
        if (rf_we && rf_waddr == ex_rs)
        begin
            op_a = rf_wdata;
        end
        else if (ex_ovr_a_reg)
        begin
            op_a = ex_ovr_a_val_reg;
        end
        else
        begin
            op_a = rf_data_a;
        end

        if (rf_we && rf_waddr == ex_rt)
        begin
            op_b = rf_wdata;
        end
        else if (ex_ovr_b_reg)
        begin
            op_b = ex_ovr_b_val_reg;
        end
        else
        begin
            op_b = rf_data_b;
        end
    end

    rle_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (accept),
        .rd_addr_a (get_rs(instruction_word)),
        .rd_addr_b (get_rt(instruction_word)),
        .rd_data_a (rf_data_a),
        .rd_data_b (rf_data_b),
        .wr_en     (rf_we),
        .wr_addr   (rf_waddr),
        .wr_data   (rf_wdata)
    );

    rle_exec u_exec (
        .kind            (ex_kind_reg),
        .instr           (ex_instr_reg),
        .pc              (pc_reg),
        .preload_address (ex_pre_addr_reg),
        .preload_value   (ex_pre_val_reg),
        .op_a            (op_a),
        .op_b            (op_b),
        .res             (ex_res),
        .mem_req         (ex_mem_req)
    );

    // Stores and preloads write, and loads read, at the edge that moves the
    // transfer into the output stage.
    rle_dmem u_dmem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ex_adv && ex_mem_req.wr_en),
        .rd_en   (ex_adv && ex_mem_req.rd_en),
        .addr    (ex_mem_req.addr),
        .wr_data (ex_mem_req.wr_data),
        .rd_data (dmem_rdata),
        .busy    (dmem_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ex_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_wpend_reg    <= 1'b0;
            pc_reg           <= '0;
            ex_ovr_a_reg     <= 1'b0;
            ex_ovr_b_reg     <= 1'b0;
        end
        else
        begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
            out_wpend_reg <= ex_adv;
            if (ex_adv)
            begin
                pc_reg <= ex_res.next_pc;
            end

            // A write at the accepting edge is missed by the read; so is any
            // write that lands while the instruction waits in the execute stage.
            if (accept)
            begin
                ex_ovr_a_reg <= rf_we && rf_waddr == get_rs(instruction_word);
                ex_ovr_b_reg <= rf_we && rf_waddr == get_rt(instruction_word);
            end
            else
            begin
                if (rf_we && rf_waddr == ex_rs)
                begin
                    ex_ovr_a_reg <= 1'b1;
                end
                if (rf_we && rf_waddr == ex_rt)
                begin
                    ex_ovr_b_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_kind_reg      <= kind;
            ex_instr_reg     <= instruction_word;
            ex_pre_addr_reg  <= preload_address;
            ex_pre_val_reg   <= preload_value;
            ex_ovr_a_val_reg <= rf_wdata;
            ex_ovr_b_val_reg <= rf_wdata;
        end
        else
        begin
            if (rf_we && rf_waddr == ex_rs)
            begin
                ex_ovr_a_val_reg <= rf_wdata;
            end
            if (rf_we && rf_waddr == ex_rt)
            begin
                ex_ovr_b_val_reg <= rf_wdata;
            end
        end

        if (ex_adv)
        begin
            out_res_reg <= ex_res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = NEXT_PC_W'(out_res_reg.next_pc);
    assign halted       = out_res_reg.halted;
    assign branch_taken = out_res_reg.taken;
    assign dest_written = out_res_reg.written;
    assign dest_index   = out_res_reg.dest;
    assign result_value = final_value;
    assign store_done   = out_res_reg.store_done;

endmodule

>>> sv/rle_regfile.sv
// Register file: one write port, two registered read ports, per-entry valid bits
// so that entries never written read as zero after reset. Depends on rle_pkg.
module rle_regfile (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [rle_pkg::REG_AW-1:0]   rd_addr_a,
    input  logic [rle_pkg::REG_AW-1:0]   rd_addr_b,
    output logic [rle_pkg::WORD_W-1:0]   rd_data_a,
    output logic [rle_pkg::WORD_W-1:0]   rd_data_b,
    input  logic                         wr_en,
    input  logic [rle_pkg::REG_AW-1:0]   wr_addr,
    input  logic [rle_pkg::WORD_W-1:0]   wr_data
);
    import rle_pkg::*;

    logic [WORD_W-1:0]         mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] valid_reg;
    logic [WORD_W-1:0]         data_a_reg;
    logic [WORD_W-1:0]         data_b_reg;
    logic                      valid_a_reg;
    logic                      valid_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                valid_a_reg <= valid_reg[rd_addr_a];
                valid_b_reg <= valid_reg[rd_addr_b];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_a_reg <= mem[rd_addr_a];
            data_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = valid_a_reg ? data_a_reg : '0;
    assign rd_data_b = valid_b_reg ? data_b_reg : '0;

endmodule

>>> sv/rle_dmem.sv
// Data memory with one write and one registered read port, plus the clearing
// sweep that zeroes every word after reset. Depends on rle_pkg.
module rle_dmem (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic                         rd_en,
    input  logic [rle_pkg::DATA_AW-1:0]  addr,
    input  logic [rle_pkg::WORD_W-1:0]   wr_data,
    output logic [rle_pkg::WORD_W-1:0]   rd_data,
    output logic                         busy
);
    import rle_pkg::*;

    logic [WORD_W-1:0]  mem [DATA_WORDS];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [DATA_AW-1:0] clr_addr_reg;
    logic               clr_busy_reg;

    // The sweep writes one zero word per cycle and stops after the last entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == DATA_AW'(DATA_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;

endmodule

>>> sv/rle_exec.sv
// Execute logic: decodes one instruction or preload transfer and produces its
// result, next program counter and data memory request. Depends on rle_pkg.
module rle_exec (
    input  logic                            kind,
    input  logic [rle_pkg::WORD_W-1:0]      instr,
    input  logic [rle_pkg::PC_W-1:0]        pc,
    input  logic [rle_pkg::PRELOAD_AW-1:0]  preload_address,
    input  logic [rle_pkg::WORD_W-1:0]      preload_value,
    input  logic [rle_pkg::WORD_W-1:0]      op_a,
    input  logic [rle_pkg::WORD_W-1:0]      op_b,
    output rle_pkg::exec_result_t           res,
    output rle_pkg::dmem_req_t              mem_req
);
    import rle_pkg::*;

    instr_op_t         op;
    logic [WORD_W-1:0] simm;
    logic [WORD_W-1:0] alu_b;
    logic [WORD_W-1:0] alu_r;
    logic [WORD_W-1:0] byte_addr;
    logic [PC_W-1:0]   seq_pc;
    logic [PC_W-1:0]   branch_pc;

    assign op        = instr_op_t'(instr[31:26]);
    assign simm      = {{(WORD_W - 16){instr[15]}}, instr[15:0]};
    // Odd ALU opcodes take the immediate as the second operand.
    assign alu_b     = instr[26] ? simm : op_b;
    assign byte_addr = op_a + simm;
    assign seq_pc    = pc + 1'b1;
    assign branch_pc = pc + simm[PC_W-1:0];

    always_comb
    begin
        case (op) inside
            OP_ADD, OP_ADDI: alu_r = op_a + alu_b;
            OP_SUB, OP_SUBI: alu_r = op_a - alu_b;
            OP_MUL, OP_MULI: alu_r = op_a * alu_b;
            OP_OR,  OP_ORI:  alu_r = op_a | alu_b;
            OP_AND, OP_ANDI: alu_r = op_a & alu_b;
            OP_XOR, OP_XORI: alu_r = op_a ^ alu_b;
            default:         alu_r = '0;
        endcase
    end

    always_comb
    begin
        res             = '0;
        res.next_pc     = seq_pc;
        mem_req         = '0;
        mem_req.addr    = byte_addr[DATA_AW+1:2];
        mem_req.wr_data = op_b;

        if (kind == KIND_PRELOAD)
        begin
            res.next_pc     = pc;
            mem_req.wr_en   = 1'b1;
            mem_req.addr    = DATA_AW'(preload_address);
            mem_req.wr_data = preload_value;
        end
        else
        begin
            unique case (op) inside
                OP_ADD, OP_SUB, OP_MUL, OP_OR, OP_AND, OP_XOR:
                begin
                    res.written = 1'b1;
                    res.dest    = get_rd(instr);
                    res.value   = alu_r;
                end
                OP_ADDI, OP_SUBI, OP_MULI, OP_ORI, OP_ANDI, OP_XORI:
                begin
                    res.written = 1'b1;
                    res.dest    = get_rt(instr);
                    res.value   = alu_r;
                end
                OP_LDW:
                begin
                    res.written   = 1'b1;
                    res.dest      = get_rt(instr);
                    res.is_load   = 1'b1;
                    mem_req.rd_en = 1'b1;
                end
                OP_STW:
                begin
                    res.value      = op_b;
                    res.store_done = 1'b1;
                    mem_req.wr_en  = 1'b1;
                end
                OP_BZ:
                begin
                    if (op_a == '0)
                    begin
                        res.next_pc = branch_pc;
                        res.taken   = 1'b1;
                    end
                end
                OP_BEQ:
                begin
                    if (op_a == op_b)
                    begin
                        res.next_pc = branch_pc;
                        res.taken   = 1'b1;
                    end
                end
                OP_JR:
                begin
                    res.next_pc = op_a[PC_W+1:2];
                    res.taken   = 1'b1;
                end
                OP_HALT:
                begin
                    res.next_pc = pc;
                    res.halted  = 1'b1;
                end
                default:
                begin
                    // Undefined opcodes only advance the program counter.
                    res.next_pc = seq_pc;
                end
            endcase
        end
    end

endmodule
